FILE: src/pts_pkg.sv
// Package with the sizes, codes and piece type of the piece-table text store.
`default_nettype none
package pts_pkg;
  localparam int MAX_PIECES = 64;
  localparam int ADD_DEPTH  = 4096;
  localparam int ORIG_DEPTH = 4096;

  localparam int POS_W    = 14;
  localparam int BYTE_W   = 8;
  localparam int ORIG_AW  = $clog2(ORIG_DEPTH);
  localparam int ADD_AW   = $clog2(ADD_DEPTH);
  localparam int OFF_W    = (ORIG_AW > ADD_AW) ? ORIG_AW : ADD_AW;
  localparam int LEN_W    = OFF_W + 1;
  localparam int OFILL_W  = $clog2(ORIG_DEPTH + 1);
  localparam int AFILL_W  = $clog2(ADD_DEPTH + 1);
  localparam int PIDX_W   = $clog2(MAX_PIECES);
  localparam int PCNT_W   = $clog2(MAX_PIECES + 3);
  localparam int PIECE_W  = 1 + OFF_W + LEN_W;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_ERASE  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_LIST_FULL  = 2'd1,
    ST_STORE_FULL = 2'd2,
    ST_LOAD_LATE  = 2'd3
  } status_t;

  localparam logic SRC_ORIG = 1'b0;
  localparam logic SRC_ADD  = 1'b1;

  typedef struct packed {
    logic             src;
    logic [OFF_W-1:0] off;
    logic [LEN_W-1:0] len;
  } piece_t;
endpackage
`default_nettype wire

FILE: src/pts_in_if.sv
// Request channel of the piece-table text store.
`default_nettype none
interface pts_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  operation;
  logic [pts_pkg::POS_W-1:0]   position;
  logic [pts_pkg::BYTE_W-1:0]  byte_value;
  logic                        last;
  logic [pts_pkg::POS_W-1:0]   erase_length;
  modport source (output valid, operation, position, byte_value, last, erase_length,
                  input ready);
  modport sink (input valid, operation, position, byte_value, last, erase_length,
                output ready);
endinterface
`default_nettype wire

FILE: src/pts_out_if.sv
// Result channel of the piece-table text store.
`default_nettype none
interface pts_out_if;
  logic                        valid;
  logic                        ready;
  logic [pts_pkg::BYTE_W-1:0]  read_byte;
  logic                        in_range;
  logic [1:0]                  status;
  logic [pts_pkg::POS_W-1:0]   text_length;
  modport source (output valid, read_byte, in_range, status, text_length, input ready);
  modport sink (input valid, read_byte, in_range, status, text_length, output ready);
endinterface
`default_nettype wire

FILE: src/pts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: src/piece_table_text_store_unit.sv
// Top level of the piece-table text store: sequencer, piece list banks and byte stores.
// A load, or an insert byte that places nothing, goes from decode straight to the
// result. A read walks the piece list through the piece RAM's single read port up to
// the hit, then reads the byte from the store that the piece names. An insert that
// places a run, or an erase, copies the whole list into the other of two piece list
// banks through one read and one write port, reading each piece and then writing the
// pieces that it yields. A failed edit leaves the old bank in use. The block takes one
// request at a time; the result waits in an output register.
`default_nettype none
module piece_table_text_store_unit (
  input wire logic  clk,
  input wire logic  rst_n,
  pts_in_if.sink    in_req,
  pts_out_if.source out_res
);
  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_PRD, S_PPROC, S_PEMIT, S_PEND, S_RDATA, S_DONE
  } state_t;

  localparam int CW = pts_pkg::POS_W + 1;

  state_t state_r;
  logic [1:0]                   op_r;
  logic [pts_pkg::POS_W-1:0]    pos_r, elen_r, run_pos_r, text_len_r;
  logic [pts_pkg::BYTE_W-1:0]   byte_r, rbyte_r;
  logic                         last_r, run_open_r, edited_r, bank_r;
  logic [pts_pkg::PCNT_W-1:0]   piece_count_r, idx_r, n_r;
  logic [pts_pkg::OFILL_W-1:0]  orig_fill_r;
  logic [pts_pkg::AFILL_W-1:0]  add_fill_r, run_start_r, run_len_r;
  logic [CW-1:0]                cur_r, end_r;
  logic                         placed_r, hit_r, rsrc_r;
  pts_pkg::piece_t              emit_r [3];
  pts_pkg::piece_t              add_piece_r;
  logic [1:0]                   ecnt_r, ek_r;
  logic [1:0]                   status_r;
  logic                         out_valid_r, out_in_range_r;
  logic [pts_pkg::BYTE_W-1:0]   out_byte_r;
  logic [1:0]                   out_status_r;
  logic [pts_pkg::POS_W-1:0]    out_len_r;

  logic                         pl_we, pl_wbank;
  logic [pts_pkg::PIDX_W-1:0]   pl_wa, pl_ra;
  pts_pkg::piece_t              pl_wd, pl_rd, pl0_rd, pl1_rd;
  logic                         orig_we, add_we;
  logic [pts_pkg::ORIG_AW-1:0]  orig_wa, orig_ra;
  logic [pts_pkg::ADD_AW-1:0]   add_wa, add_ra;
  logic [pts_pkg::BYTE_W-1:0]   orig_rd, add_rd;

  logic [CW-1:0]                pe_c, pos_ins_c, pos_e_c, local_c, k_c;
  logic [pts_pkg::LEN_W-1:0]    loc_c;
  pts_pkg::piece_t              e_c [3];
  pts_pkg::piece_t              p_left_c, p_right_c, e_left_c, e_right_c;
  logic [1:0]                   ecnt_c;
  logic                         placed_c, rhit_c, has_l_c, has_r_c;

  logic                         ins_start_c;
  logic [pts_pkg::AFILL_W-1:0]  start_c, fill_c, rl_c;
  logic [pts_pkg::POS_W-1:0]    rpos_c;
  logic                         afull_c;
  logic [CW-1:0]                eend_c;
  logic [pts_pkg::PCNT_W-1:0]   nfinal_c;

  pts_ram #(.WIDTH(pts_pkg::PIECE_W), .DEPTH(pts_pkg::MAX_PIECES)) u_pl0 (
    .clk(clk), .we(pl_we && !pl_wbank), .waddr(pl_wa), .wdata(pl_wd),
    .raddr(pl_ra), .rdata(pl0_rd)
  );
  pts_ram #(.WIDTH(pts_pkg::PIECE_W), .DEPTH(pts_pkg::MAX_PIECES)) u_pl1 (
    .clk(clk), .we(pl_we && pl_wbank), .waddr(pl_wa), .wdata(pl_wd),
    .raddr(pl_ra), .rdata(pl1_rd)
  );
  pts_ram #(.WIDTH(pts_pkg::BYTE_W), .DEPTH(pts_pkg::ORIG_DEPTH)) u_orig (
    .clk(clk), .we(orig_we), .waddr(orig_wa), .wdata(byte_r),
    .raddr(orig_ra), .rdata(orig_rd)
  );
  pts_ram #(.WIDTH(pts_pkg::BYTE_W), .DEPTH(pts_pkg::ADD_DEPTH)) u_add (
    .clk(clk), .we(add_we), .waddr(add_wa), .wdata(byte_r),
    .raddr(add_ra), .rdata(add_rd)
  );

  assign pl_rd = bank_r ? pl1_rd : pl0_rd;

  // Request decode for insert and erase.
  always_comb begin
    ins_start_c = !run_open_r;
    start_c = ins_start_c ? add_fill_r : run_start_r;
    rpos_c  = ins_start_c ? pos_r : run_pos_r;
    afull_c = (add_fill_r >= pts_pkg::AFILL_W'(pts_pkg::ADD_DEPTH));
    fill_c  = afull_c ? add_fill_r : add_fill_r + 1'b1;
    rl_c    = fill_c - start_c;
    eend_c  = {1'b0, pos_r} + {1'b0, elen_r};
    if (eend_c > {1'b0, text_len_r}) begin
      eend_c = {1'b0, text_len_r};
    end
    nfinal_c = n_r + ((op_r == pts_pkg::OP_INSERT && !placed_r) ? 1'b1 : 1'b0);
  end

  // Per-piece splice and clip logic on the piece just read.
  always_comb begin
    pe_c      = cur_r + CW'(pl_rd.len);
    pos_ins_c = {1'b0, run_pos_r};
    pos_e_c   = {1'b0, pos_r};
    local_c   = pos_ins_c - cur_r;
    loc_c     = pts_pkg::LEN_W'(local_c);
    k_c       = CW'(pl_rd.off) + (pos_e_c - cur_r);
    rhit_c    = (pe_c > pos_e_c);
    p_left_c  = '{src: pl_rd.src, off: pl_rd.off, len: loc_c};
    p_right_c = '{src: pl_rd.src, off: pl_rd.off + pts_pkg::OFF_W'(loc_c),
                  len: pl_rd.len - loc_c};
    e_left_c  = '{src: pl_rd.src, off: pl_rd.off,
                  len: pts_pkg::LEN_W'(pos_e_c - cur_r)};
    e_right_c = '{src: pl_rd.src, off: pl_rd.off + pts_pkg::OFF_W'(end_r - cur_r),
                  len: pts_pkg::LEN_W'(pe_c - end_r)};
    has_l_c   = (cur_r < pos_e_c);
    has_r_c   = (pe_c > end_r);
    placed_c  = placed_r;
    e_c[0] = pl_rd;
    e_c[1] = pl_rd;
    e_c[2] = pl_rd;
    ecnt_c = 2'd1;
    if (op_r == pts_pkg::OP_INSERT) begin
      if (!placed_r && pe_c >= pos_ins_c) begin
        placed_c = 1'b1;
        if (loc_c == '0) begin
          e_c[0] = add_piece_r;
          ecnt_c = 2'd2;
        end else if (loc_c == pl_rd.len) begin
          e_c[1] = add_piece_r;
          ecnt_c = 2'd2;
        end else begin
          e_c[0] = p_left_c;
          e_c[1] = add_piece_r;
          e_c[2] = p_right_c;
          ecnt_c = 2'd3;
        end
      end
    end else if (!(pe_c <= pos_e_c || cur_r >= end_r)) begin
      e_c[0] = has_l_c ? e_left_c : e_right_c;
      e_c[1] = e_right_c;
      ecnt_c = {1'b0, has_l_c} + {1'b0, has_r_c};
    end
  end

  // Memory port control.
  always_comb begin
    pl_we    = 1'b0;
    pl_wbank = !bank_r;
    pl_wa    = pts_pkg::PIDX_W'(n_r);
    pl_wd    = emit_r[ek_r];
    pl_ra    = pts_pkg::PIDX_W'(idx_r);
    orig_we  = 1'b0;
    orig_wa  = pts_pkg::ORIG_AW'(orig_fill_r);
    orig_ra  = pts_pkg::ORIG_AW'(k_c);
    add_we   = 1'b0;
    add_wa   = pts_pkg::ADD_AW'(add_fill_r);
    add_ra   = pts_pkg::ADD_AW'(k_c);
    case (state_r)
      S_EXEC: begin
        if (op_r == pts_pkg::OP_LOAD && !edited_r &&
            orig_fill_r < pts_pkg::OFILL_W'(pts_pkg::ORIG_DEPTH)) begin
          orig_we  = 1'b1;
          pl_we    = 1'b1;
          pl_wbank = bank_r;
          pl_wa    = '0;
          pl_wd    = '{src: pts_pkg::SRC_ORIG, off: '0,
                       len: pts_pkg::LEN_W'(orig_fill_r) + 1'b1};
        end
        if (op_r == pts_pkg::OP_INSERT && !afull_c) begin
          add_we = 1'b1;
        end
      end
      S_PEMIT: begin
        pl_we = (n_r < pts_pkg::PCNT_W'(pts_pkg::MAX_PIECES));
      end
      S_PEND: begin
        pl_wd = add_piece_r;
        pl_we = (op_r == pts_pkg::OP_INSERT) && !placed_r &&
                (n_r < pts_pkg::PCNT_W'(pts_pkg::MAX_PIECES));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      piece_count_r <= '0;
      orig_fill_r   <= '0;
      add_fill_r    <= '0;
      run_pos_r     <= '0;
      run_start_r   <= '0;
      run_open_r    <= 1'b0;
      edited_r      <= 1'b0;
      bank_r        <= 1'b0;
      text_len_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (out_valid_r && out_res.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_req.valid) begin
            op_r    <= in_req.operation;
            pos_r   <= in_req.position;
            byte_r  <= in_req.byte_value;
            last_r  <= in_req.last;
            elen_r  <= in_req.erase_length;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          hit_r    <= 1'b0;
          rbyte_r  <= '0;
          idx_r    <= '0;
          cur_r    <= '0;
          n_r      <= '0;
          placed_r <= 1'b0;
          case (op_r)
            pts_pkg::OP_LOAD: begin
              state_r <= S_DONE;
              if (edited_r) begin
                status_r <= pts_pkg::ST_LOAD_LATE;
              end else if (orig_fill_r >= pts_pkg::OFILL_W'(pts_pkg::ORIG_DEPTH)) begin
                status_r <= pts_pkg::ST_STORE_FULL;
              end else begin
                status_r      <= pts_pkg::ST_OK;
                orig_fill_r   <= orig_fill_r + 1'b1;
                piece_count_r <= pts_pkg::PCNT_W'(1);
                text_len_r    <= text_len_r + 1'b1;
              end
            end
            pts_pkg::OP_INSERT: begin
              edited_r    <= 1'b1;
              add_fill_r  <= fill_c;
              run_pos_r   <= rpos_c;
              run_start_r <= start_c;
              run_open_r  <= !last_r;
              status_r    <= afull_c ? pts_pkg::ST_STORE_FULL : pts_pkg::ST_OK;
              add_piece_r <= '{src: pts_pkg::SRC_ADD, off: pts_pkg::OFF_W'(start_c),
                               len: pts_pkg::LEN_W'(rl_c)};
              run_len_r   <= rl_c;
              state_r     <= (last_r && rl_c != '0) ? S_PRD : S_DONE;
            end
            pts_pkg::OP_ERASE: begin
              edited_r <= 1'b1;
              end_r    <= eend_c;
              status_r <= pts_pkg::ST_OK;
              state_r  <= (elen_r != '0 && pos_r < text_len_r) ? S_PRD : S_DONE;
            end
            default: begin
              status_r <= pts_pkg::ST_OK;
              state_r  <= S_PRD;
            end
          endcase
        end
        S_PRD: begin
          if (idx_r == piece_count_r) begin
            state_r <= (op_r == pts_pkg::OP_READ) ? S_DONE : S_PEND;
          end else begin
            state_r <= S_PPROC;
          end
        end
        S_PPROC: begin
          idx_r <= idx_r + 1'b1;
          cur_r <= pe_c;
          if (op_r == pts_pkg::OP_READ) begin
            rsrc_r  <= pl_rd.src;
            state_r <= rhit_c ? S_RDATA : S_PRD;
          end else begin
            emit_r   <= e_c;
            ecnt_r   <= ecnt_c;
            ek_r     <= '0;
            placed_r <= placed_c;
            state_r  <= (ecnt_c == 2'd0) ? S_PRD : S_PEMIT;
          end
        end
        S_PEMIT: begin
          n_r  <= n_r + 1'b1;
          ek_r <= ek_r + 1'b1;
          if (ek_r == ecnt_r - 2'd1) begin
            state_r <= S_PRD;
          end
        end
        S_PEND: begin
          if (nfinal_c > pts_pkg::PCNT_W'(pts_pkg::MAX_PIECES)) begin
            status_r <= pts_pkg::ST_LIST_FULL;
          end else begin
            bank_r        <= !bank_r;
            piece_count_r <= nfinal_c;
            if (op_r == pts_pkg::OP_INSERT) begin
              text_len_r <= text_len_r + pts_pkg::POS_W'(run_len_r);
            end else begin
              text_len_r <= text_len_r - pts_pkg::POS_W'(end_r - {1'b0, pos_r});
            end
          end
          state_r <= S_DONE;
        end
        S_RDATA: begin
          hit_r   <= 1'b1;
          rbyte_r <= (rsrc_r == pts_pkg::SRC_ADD) ? add_rd : orig_rd;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_res.ready) begin
            out_valid_r    <= 1'b1;
            out_byte_r     <= rbyte_r;
            out_in_range_r <= hit_r;
            out_status_r   <= status_r;
            out_len_r      <= text_len_r;
            state_r        <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_req.ready        = (state_r == S_IDLE);
  assign out_res.valid       = out_valid_r;
  assign out_res.read_byte   = out_byte_r;
  assign out_res.in_range    = out_in_range_r;
  assign out_res.status      = out_status_r;
  assign out_res.text_length = out_len_r;
endmodule
`default_nettype wire
